FILE: sv/utf8vd_pkg.sv
`default_nettype none

package utf8vd_pkg;

    // Lead byte ranges.
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;

    // Leads whose first continuation byte has a narrowed range.
    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_ED = 8'hED;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;

    localparam logic [7:0] CONT_MIN = 8'h80;
    localparam logic [7:0] CONT_MAX = 8'hBF;
    localparam logic [7:0] E0_MIN   = 8'hA0;
    localparam logic [7:0] ED_MAX   = 8'h9F;
    localparam logic [7:0] F0_MIN   = 8'h90;
    localparam logic [7:0] F4_MAX   = 8'h8F;

    // Result queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [20:0] scalar_value;
        logic        ok;
        logic [2:0]  count;
    } result_t;

    // One queue entry holds every result that a single input item causes.
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

FILE: sv/utf8vd_front.sv
`default_nettype none

module utf8vd_front
    import utf8vd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_input,
    output entry_t          push_entry,
    output logic            push
);

    typedef struct packed {
        logic        opens;
        logic [1:0]  need;
        logic [20:0] bits;
        result_t     res;
    } lead_t;

    logic [1:0]  need_reg, need_next;
    logic [1:0]  seen_reg, seen_next;
    logic [7:0]  lead_reg, lead_next;
    logic [20:0] partial_reg, partial_next;

    lead_t       lead;
    result_t     lead_res;
    logic        lead_holds;
    logic        cont_ok;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [20:0] shifted;
    logic [1:0]  seen_inc;
    logic [1:0]  need_dec;

    always_comb
    begin
        lead = '0;
        case (data_byte) inside
            [8'h00:ASCII_MAX]:
            begin
                lead.res = '{scalar_value: {13'd0, data_byte}, ok: 1'b1, count: 3'd1};
            end
            [LEAD2_MIN:LEAD2_MAX]:
            begin
                lead.opens = 1'b1;
                lead.need  = 2'd1;
                lead.bits  = {16'd0, data_byte[4:0]};
            end
            [LEAD3_MIN:LEAD3_MAX]:
            begin
                lead.opens = 1'b1;
                lead.need  = 2'd2;
                lead.bits  = {17'd0, data_byte[3:0]};
            end
            [LEAD4_MIN:LEAD4_MAX]:
            begin
                lead.opens = 1'b1;
                lead.need  = 2'd3;
                lead.bits  = {18'd0, data_byte[2:0]};
            end
            default:
            begin
                lead.res = '{scalar_value: 21'd0, ok: 1'b0, count: 3'd1};
            end
        endcase
        // A lead that opens a sequence on the last item of the stream is an error.
        lead_holds = lead.opens && !end_of_input;
        lead_res   = lead.opens ? result_t'{scalar_value: 21'd0, ok: 1'b0, count: 3'd1}
                                : lead.res;
    end

    always_comb
    begin
        lo = CONT_MIN;
        hi = CONT_MAX;
        if (seen_reg == 2'd0)
        begin
            case (lead_reg)
                LEAD_E0: lo = E0_MIN;
                LEAD_ED: hi = ED_MAX;
                LEAD_F0: lo = F0_MIN;
                LEAD_F4: hi = F4_MAX;
                default: ;
            endcase
        end
        cont_ok = (data_byte >= lo) && (data_byte <= hi);
    end

    assign shifted  = {partial_reg[14:0], data_byte[5:0]};
    assign seen_inc = seen_reg + 2'd1;
    assign need_dec = need_reg - 2'd1;

    always_comb
    begin
        need_next    = need_reg;
        seen_next    = seen_reg;
        lead_next    = lead_reg;
        partial_next = partial_reg;
        push         = 1'b0;
        push_entry   = '0;
        if (accept)
        begin
            if (need_reg == 2'd0)
            begin
                if (lead_holds)
                begin
                    need_next    = lead.need;
                    seen_next    = 2'd0;
                    lead_next    = data_byte;
                    partial_next = lead.bits;
                end
                else
                begin
                    push             = 1'b1;
                    push_entry.first = lead_res;
                end
            end
            else if (cont_ok)
            begin
                if (need_dec == 2'd0 || end_of_input)
                begin
                    push         = 1'b1;
                    push_entry.first.scalar_value = (need_dec == 2'd0) ? shifted : 21'd0;
                    push_entry.first.ok           = (need_dec == 2'd0);
                    push_entry.first.count        = {1'b0, seen_inc} + 3'd1;
                    need_next    = 2'd0;
                    seen_next    = 2'd0;
                    lead_next    = 8'd0;
                    partial_next = 21'd0;
                end
                else
                begin
                    need_next    = need_dec;
                    seen_next    = seen_inc;
                    partial_next = shifted;
                end
            end
            else
            begin
                // The failing byte ends the sequence and is then taken as a new lead.
                push                          = 1'b1;
                push_entry.first.scalar_value = 21'd0;
                push_entry.first.ok           = 1'b0;
                push_entry.first.count        = {1'b0, seen_reg} + 3'd1;
                push_entry.two                = !lead_holds;
                push_entry.second             = lead_res;
                need_next    = lead_holds ? lead.need : 2'd0;
                seen_next    = 2'd0;
                lead_next    = lead_holds ? data_byte : 8'd0;
                partial_next = lead_holds ? lead.bits : 21'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg    <= 2'd0;
            seen_reg    <= 2'd0;
            lead_reg    <= 8'd0;
            partial_reg <= 21'd0;
        end
        else
        begin
            need_reg    <= need_next;
            seen_reg    <= seen_next;
            lead_reg    <= lead_next;
            partial_reg <= partial_next;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, need_reg} + {1'b0, seen_reg}) <= 3'd3)
        else $error("pending sequence longer than four bytes");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (need_reg == 2'd0) |-> (seen_reg == 2'd0 && lead_reg == 8'd0 && partial_reg == 21'd0))
        else $error("idle decoder holds stale sequence state");

endmodule

`default_nettype wire

FILE: sv/utf8vd_queue.sv
`default_nettype none

module utf8vd_queue
    import utf8vd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      head,
    output q_status_t   status
);

    entry_t           mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.empty = (count_reg == QCW'(0));
    assign status.full  = (count_reg == QCW'(QDEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + QCW'(do_push) - QCW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full))
        else $error("item pushed into a full result queue");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QAW-1:0])
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

FILE: sv/utf8vd_back.sv
`default_nettype none

module utf8vd_back
    import utf8vd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire entry_t      head,
    input  wire q_status_t   status,
    output logic             pop,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [20:0]      scalar_value,
    output logic             valid_res,
    output logic [2:0]       byte_count,
    output logic             last_of_run
);

    logic    second_reg, second_next;
    logic    valid_reg, valid_next;
    result_t res_reg;
    logic    last_reg;
    logic    load;
    logic    is_last;
    result_t pick;

    // The output register takes a new result whenever it is empty or being drained and the queue is not empty.
    assign load    = (!valid_reg || !res_stall) && !status.empty;
    assign is_last = second_reg || !head.two;
    assign pick    = second_reg ? head.second : head.first;
    assign pop     = load && is_last;

    always_comb
    begin
        second_next = second_reg;
        valid_next  = valid_reg;
        if (!valid_reg || !res_stall)
        begin
            valid_next = !status.empty;
        end
        if (load)
        begin
            second_next = !is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= pick;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
            valid_reg  <= valid_next;
        end
    end

    assign res_valid    = valid_reg;
    assign scalar_value = res_reg.scalar_value;
    assign valid_res    = res_reg.ok;
    assign byte_count   = res_reg.count;
    assign last_of_run  = last_reg;

    a_second_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (!status.empty && head.two))
        else $error("second result pending without a two-result entry");

endmodule

`default_nettype wire

FILE: sv/utf8_validating_decoder.sv
// Validating UTF-8 decoder.
// Input channel: one byte of the stream per item on data_byte, with end_of_input
// set on the last byte; byte_valid offers it, byte_stall holds it back.
// Output channel: one result per item on scalar_value, valid_res, byte_count and
// last_of_run; res_valid offers it, res_stall holds it back. An input byte causes
// none, one or two results, and last_of_run marks the final one for that byte.
// The front classifies each byte against the pending sequence registers and
// writes its results into a four-entry queue; the back drains that queue
// through an output register, one result per cycle while res_stall is low.
// A result passes through the queue and then the output register before it is offered.
// Bytes are taken one per cycle; the output port limits the rate to one result
// per cycle, so bytes giving two results (an ill-formed sequence followed by a
// lead that does not open a new one) fill the queue and then raise byte_stall.
// Reset clears the sequence state and the queue and empties the output register;
// no result is offered until a byte has been taken. When res_stall is high the
// shown result holds, and the queue keeps taking bytes until it is full.
`default_nettype none

module utf8_validating_decoder
    import utf8vd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_input,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [20:0]      scalar_value,
    output logic             valid_res,
    output logic [2:0]       byte_count,
    output logic             last_of_run
);

    entry_t    push_entry;
    entry_t    head;
    q_status_t status;
    logic      push;
    logic      pop;
    logic      accept;

    assign byte_stall = status.full;
    assign accept     = byte_valid && !byte_stall;

    utf8vd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .push_entry   (push_entry),
        .push         (push)
    );

    utf8vd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    utf8vd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .status       (status),
        .pop          (pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .scalar_value (scalar_value),
        .valid_res    (valid_res),
        .byte_count   (byte_count),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

FILE: tb/utf8_validating_decoder_tb.sv
`timescale 1ns / 1ps

module utf8_validating_decoder_tb;
    import utf8vd_pkg::*;

    typedef struct packed {
        logic [20:0] scalar_value;
        logic        well_formed;
        logic [2:0]  nbytes;
        logic        last;
    } decoded_char_t;

    typedef struct {
        logic [7:0] value;
        logic       last_byte;
        int         gap_after;
        bit         drain;
    } stream_item_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        end_of_input = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [20:0] scalar_value;
    logic        valid_res;
    logic [2:0]  byte_count;
    logic        last_of_run;

    stream_item_t  stream_bytes[$];
    decoded_char_t pending_decodes[$];

    // Predictor copy of the sequence registers.
    logic [1:0]  seq_left = 2'd0;
    logic [1:0]  seq_seen = 2'd0;
    logic [7:0]  seq_lead = 8'd0;
    logic [20:0] seq_bits = 21'd0;
    decoded_char_t step_res[2];
    int step_n;

    int results_due = 0;
    int results_seen = 0;
    int bytes_sent = 0;
    int stream_total = 0;
    int fail_count = 0;
    int idle_left = 0;
    int stall_left = 0;
    int gap_calm = 0;
    int stall_calm = 0;
    decoded_char_t want;

    utf8_validating_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .scalar_value (scalar_value),
        .valid_res    (valid_res),
        .byte_count   (byte_count),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function void drop_sequence();
        seq_left = 2'd0;
        seq_seen = 2'd0;
        seq_lead = 8'd0;
        seq_bits = 21'd0;
    endfunction

    function void add_result(input logic [20:0] cp, input logic ok, input logic [2:0] cnt);
        step_res[step_n] = '{scalar_value: cp, well_formed: ok, nbytes: cnt, last: 1'b0};
        step_n++;
    endfunction

    function void take_lead(input logic [7:0] b, input logic eoi);
        logic [1:0]  need;
        logic [20:0] bits;
        need = 2'd0;
        bits = 21'd0;
        if (b <= ASCII_MAX)
        begin
            add_result({13'd0, b}, 1'b1, 3'd1);
            return;
        end
        if (b >= LEAD2_MIN && b <= LEAD2_MAX)
        begin
            need = 2'd1;
            bits = {16'd0, b[4:0]};
        end
        else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
        begin
            need = 2'd2;
            bits = {17'd0, b[3:0]};
        end
        else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
        begin
            need = 2'd3;
            bits = {18'd0, b[2:0]};
        end
        else
        begin
            add_result(21'd0, 1'b0, 3'd1);
            return;
        end
        if (eoi)
        begin
            drop_sequence();
            add_result(21'd0, 1'b0, 3'd1);
            return;
        end
        seq_left = need;
        seq_seen = 2'd0;
        seq_lead = b;
        seq_bits = bits;
    endfunction

    // The first continuation byte after E0, ED, F0 and F4 has a narrowed range.
    function bit cont_in_range(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_MIN;
        hi = CONT_MAX;
        if (seq_seen == 2'd0)
        begin
            if (seq_lead == LEAD_E0)
                lo = E0_MIN;
            else if (seq_lead == LEAD_ED)
                hi = ED_MAX;
            else if (seq_lead == LEAD_F0)
                lo = F0_MIN;
            else if (seq_lead == LEAD_F4)
                hi = F4_MAX;
        end
        return (b >= lo) && (b <= hi);
    endfunction

    function void decode_byte(input logic [7:0] b, input logic eoi);
        int i;
        step_n = 0;
        if (seq_left == 2'd0)
            take_lead(b, eoi);
        else if (cont_in_range(b))
        begin
            seq_bits = {seq_bits[14:0], b[5:0]};
            seq_seen = seq_seen + 2'd1;
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0)
            begin
                add_result(seq_bits, 1'b1, {1'b0, seq_seen} + 3'd1);
                drop_sequence();
            end
            else if (eoi)
            begin
                add_result(21'd0, 1'b0, {1'b0, seq_seen} + 3'd1);
                drop_sequence();
            end
        end
        else
        begin
            // The offending byte is taken again as a lead after the error.
            add_result(21'd0, 1'b0, {1'b0, seq_seen} + 3'd1);
            drop_sequence();
            take_lead(b, eoi);
        end
        for (i = 0; i < step_n; i++)
        begin
            step_res[i].last = (i == step_n - 1);
            pending_decodes.push_back(step_res[i]);
            results_due++;
        end
    endfunction

    function int next_gap();
        int r;
        if (gap_calm > 0)
        begin
            gap_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            gap_calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 50);
    endfunction

    function int next_stall();
        int r;
        if (stall_calm > 0)
        begin
            stall_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            stall_calm = $urandom_range(30, 90);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 99)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Every 137th item waits for all outstanding results, the first of them
    // right after the directed bytes.
    function void queue_byte(input logic [7:0] b, input logic eoi);
        stream_item_t item;
        item.value = b;
        item.last_byte = eoi;
        item.gap_after = next_gap();
        item.drain = (stream_bytes.size() % 137 == 25);
        stream_bytes.push_back(item);
    endfunction

    function logic [20:0] random_scalar(input int len);
        logic [20:0] cp;
        int pick;
        pick = $urandom_range(0, 9);
        case (len)
            1:
                cp = (pick == 0) ? 21'h0 : (pick == 1) ? 21'h7F
                   : 21'($urandom_range(0, 'h7F));
            2:
                cp = (pick == 0) ? 21'h80 : (pick == 1) ? 21'h7FF
                   : 21'($urandom_range('h80, 'h7FF));
            3:
            begin
                if (pick == 0)
                    cp = 21'h800;
                else if (pick == 1)
                    cp = 21'hFFFF;
                else if (pick == 2)
                    cp = 21'hD7FF;
                else if (pick == 3)
                    cp = 21'hE000;
                else
                    cp = 21'($urandom_range('h800, 'hFFFF));
                // Surrogates cannot be encoded, so move them out of that range.
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp[14] = 1'b0;
            end
            default:
                cp = (pick == 0) ? 21'h10000 : (pick == 1) ? 21'h10FFFF
                   : 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    function void queue_char(input logic [20:0] cp, input int len, input int cut,
                             input logic eoi_last);
        logic [7:0] enc [4];
        int i;
        enc[1] = 8'd0;
        enc[2] = 8'd0;
        enc[3] = 8'd0;
        case (len)
            1:
                enc[0] = {1'b0, cp[6:0]};
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (i = 0; i < cut; i++)
            queue_byte(enc[i], (i == cut - 1) ? eoi_last : 1'b0);
    endfunction

    // Sender: holds a stalled item, otherwise counts down its gap or presents
    // the next queued item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            data_byte <= 8'd0;
            end_of_input <= 1'b0;
            idle_left = 0;
        end
        else if (!(byte_valid && byte_stall))
        begin
            if (byte_valid)
            begin
                decode_byte(data_byte, end_of_input);
                bytes_sent++;
            end
            if (idle_left > 0)
            begin
                idle_left--;
                byte_valid <= 1'b0;
            end
            else if (stream_bytes.size() != 0
                     && (!stream_bytes[0].drain || results_seen >= results_due))
            begin
                data_byte <= stream_bytes[0].value;
                end_of_input <= stream_bytes[0].last_byte;
                idle_left = stream_bytes[0].gap_after;
                byte_valid <= 1'b1;
                void'(stream_bytes.pop_front());
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // Receiver: checks each accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_decodes.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result %0d: cp %h ok %b count %0d last %b",
                                 results_seen, scalar_value, valid_res, byte_count,
                                 last_of_run);
                    fail_count++;
                end
                else
                begin
                    want = pending_decodes.pop_front();
                    if (scalar_value !== want.scalar_value || valid_res !== want.well_formed
                        || byte_count !== want.nbytes || last_of_run !== want.last)
                    begin
                        if (fail_count < 10)
                            $display({"Mismatch on result %0d: expected cp %h ok %b ",
                                      "count %0d last %b, got cp %h ok %b count %0d last %b"},
                                     results_seen, want.scalar_value, want.well_formed,
                                     want.nbytes, want.last, scalar_value, valid_res,
                                     byte_count, last_of_run);
                        fail_count++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
                stall_left = next_stall();
            end
        end
    end

    initial
    begin
        logic [8:0] directed [25];
        logic [7:0] lead;
        logic [7:0] nxt;
        int i;
        int r;
        int len;
        int need;
        int wait_cycles;

        // Each entry is {end_of_input, byte}.
        directed = '{9'h000, 9'h07F, 9'h080, 9'h0C0, 9'h0FF,
                     9'h0C2, 9'h080, 9'h0DF, 9'h0BF,
                     9'h0E0, 9'h09F, 9'h0ED, 9'h0A0,
                     9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
                     9'h0F0, 9'h08F, 9'h0E1, 9'h080, 9'h041,
                     9'h0E2, 9'h182, 9'h1C3};
        for (i = 0; i < 25; i++)
            queue_byte(directed[i][7:0], directed[i][8]);

        while (stream_bytes.size() < 550)
        begin
            r = $urandom_range(0, 99);
            len = $urandom_range(1, 4);
            if (r < 55)
                queue_char(random_scalar(len), len, len, $urandom_range(0, 29) == 0);
            else if (r < 70)
            begin
                // Cut a valid sequence short and follow it with any byte.
                len = $urandom_range(2, 4);
                queue_char(random_scalar(len), len, $urandom_range(1, len - 1), 1'b0);
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            end
            else if (r < 80)
            begin
                case ($urandom_range(0, 3))
                    0: lead = LEAD_E0;
                    1: lead = LEAD_ED;
                    2: lead = LEAD_F0;
                    default: lead = LEAD_F4;
                endcase
                if ($urandom_range(0, 4) < 2)
                begin
                    case ($urandom_range(0, 9))
                        0: nxt = E0_MIN - 8'd1;
                        1: nxt = E0_MIN;
                        2: nxt = ED_MAX;
                        3: nxt = ED_MAX + 8'd1;
                        4: nxt = F0_MIN - 8'd1;
                        5: nxt = F0_MIN;
                        6: nxt = F4_MAX;
                        7: nxt = F4_MAX + 8'd1;
                        8: nxt = CONT_MIN;
                        default: nxt = CONT_MAX;
                    endcase
                end
                else
                    nxt = 8'($urandom_range(CONT_MIN, CONT_MAX));
                need = (lead >= LEAD4_MIN) ? 3 : 2;
                queue_byte(lead, 1'b0);
                queue_byte(nxt, 1'b0);
                for (i = 1; i < need; i++)
                    queue_byte(8'($urandom_range(CONT_MIN, CONT_MAX)), 1'b0);
            end
            else if (r < 90)
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            else
            begin
                // Stream ends in the middle of a sequence.
                len = $urandom_range(2, 4);
                queue_char(random_scalar(len), len, $urandom_range(1, len - 1), 1'b1);
            end
        end
        stream_total = stream_bytes.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_sent < stream_total)
            @(negedge clk);
        wait_cycles = 0;
        while (results_seen < results_due && wait_cycles < 5000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (10) @(negedge clk);

        if (pending_decodes.size() != 0)
        begin
            $display("%0d predicted results never arrived", pending_decodes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", results_due - results_seen);
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: utf8_validating_decoder.f
sv/utf8vd_pkg.sv
sv/utf8vd_front.sv
sv/utf8vd_queue.sv
sv/utf8vd_back.sv
sv/utf8_validating_decoder.sv
tb/utf8_validating_decoder_tb.sv
